@@ rtl/rsvp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsvp_pkg: shared definitions for the ray-sphere vertex pick unit
// Register indexes, reset constants, multiplier operation codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsvp_pkg;

  // Default coordinate width (signed Q16.8).
  localparam int COORD_BITS_DEF = 24;

  // Configuration write channel.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_X     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Y     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Z     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_SQ = 3'd6;

  // Squared radius register and its reset value (30 units squared, Q.16).
  localparam int RADIUS_BITS = 32;
  localparam logic [RADIUS_BITS-1:0] RADIUS_SQ_RESET = 32'd58982400;

  // Ray direction z resets to one unit in Q16.8.
  localparam int DIR_Z_RESET = 256;

  // Best squared distance register and the pick limit (10000 units squared).
  localparam int DIST_BITS = 52;
  localparam logic [DIST_BITS-1:0] LIMIT_DIST_SQ = 52'd6553600000000;

  // Operations issued to the shared multiplier.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SS,      // |d|*|d|  into S
    OP_PN,      // |v|*|d|  into P or N by sign
    OP_AA,      // |v|*|v|  into A
    OP_BB_LL,   // B*B partial products
    OP_BB_LH,
    OP_BB_HH,
    OP_AC_LL,   // A*C partial products
    OP_AC_LH,
    OP_AC_HL,
    OP_AC_HH
  } mul_op_t;

  // Controller to datapath.
  typedef struct packed {
    mul_op_t    op;
    logic [1:0] axis;
    logic       load;
    logic       prep;
    logic       update;
    logic       emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
    logic s_le_r;
    logic p_le_n;
    logic bb_ge_ac;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/rsvp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rsvp_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsvp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rsvp_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [rsvp_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rsvp_vert_if.sv @@
// ----------------------------------------------------------------------------
// rsvp_vert_if: vertex input channel
// One vertex position per transfer, with a flag on the last vertex of a pick.
// ----------------------------------------------------------------------------
interface rsvp_vert_if #(
  parameter int COORD_BITS = rsvp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] vert_z;
  logic                         last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

@@ rtl/rsvp_pick_if.sv @@
// ----------------------------------------------------------------------------
// rsvp_pick_if: pick result channel
// Hit flag and picked vertex position, one transfer per finished pick.
// ----------------------------------------------------------------------------
interface rsvp_pick_if #(
  parameter int COORD_BITS = rsvp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] pick_x;
  logic signed [COORD_BITS-1:0] pick_y;
  logic signed [COORD_BITS-1:0] pick_z;

  modport source (output valid, hit, pick_x, pick_y, pick_z, input ready);
  modport sink   (input valid, hit, pick_x, pick_y, pick_z, output ready);
endinterface

@@ rtl/rsvp_cfg.sv @@
// ----------------------------------------------------------------------------
// rsvp_cfg: configuration register file
// Holds the ray origin, ray direction and squared sphere radius.
// ----------------------------------------------------------------------------
module rsvp_cfg #(
  parameter int COORD_BITS = rsvp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  rsvp_cfg_if.sink                            cfg,
  output logic [2:0][COORD_BITS-1:0]          origin,
  output logic [2:0][COORD_BITS-1:0]          dir,
  output logic [rsvp_pkg::RADIUS_BITS-1:0]    radius_sq
);
  import rsvp_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin    <= '0;
      dir[0]    <= '0;
      dir[1]    <= '0;
      dir[2]    <= COORD_BITS'(DIR_Z_RESET);
      radius_sq <= RADIUS_SQ_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X:  origin[0] <= cfg.data[COORD_BITS-1:0];
        REG_ORIGIN_Y:  origin[1] <= cfg.data[COORD_BITS-1:0];
        REG_ORIGIN_Z:  origin[2] <= cfg.data[COORD_BITS-1:0];
        REG_DIR_X:     dir[0]    <= cfg.data[COORD_BITS-1:0];
        REG_DIR_Y:     dir[1]    <= cfg.data[COORD_BITS-1:0];
        REG_DIR_Z:     dir[2]    <= cfg.data[COORD_BITS-1:0];
        REG_RADIUS_SQ: radius_sq <= cfg.data[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/rsvp_dp.sv @@
// ----------------------------------------------------------------------------
// rsvp_dp: pick datapath
// Offset and magnitude registers, one shared multiplier with a product
// register, the S/P/N/A and B*B/A*C accumulators, the running best vertex
// and the result register.
// ----------------------------------------------------------------------------
module rsvp_dp #(
  parameter int COORD_BITS = rsvp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rsvp_pkg::dp_cmd_t                 cmd,
  output rsvp_pkg::dp_status_t              status,
  input  logic [2:0][COORD_BITS-1:0]        origin,
  input  logic [2:0][COORD_BITS-1:0]        dir,
  input  logic [rsvp_pkg::RADIUS_BITS-1:0]  radius_sq,
  input  logic [COORD_BITS-1:0]             vert_x,
  input  logic [COORD_BITS-1:0]             vert_y,
  input  logic [COORD_BITS-1:0]             vert_z,
  input  logic                              last_vertex,
  rsvp_pick_if.source                       pick
);
  import rsvp_pkg::*;

  // Operand width holds a coordinate difference magnitude; the sums of
  // three squares fit twice that, and the wide products four times.
  localparam int W  = COORD_BITS + 1;
  localparam int AW = 2 * W;
  localparam int PW = 4 * W;
  localparam int CW = (AW > DIST_BITS) ? AW : DIST_BITS;

  logic [2:0][COORD_BITS-1:0] vin;
  logic [2:0][COORD_BITS-1:0] vert;
  logic                       last;
  logic [2:0][W-1:0]          dmag, dmag_next, vmag;
  logic [2:0]                 dneg, dneg_next, vneg;

  logic [W-1:0]  mul_a, mul_b;
  logic          mul_neg;
  logic [AW-1:0] prod;
  mul_op_t       prod_op;
  logic          prod_neg;

  logic [AW-1:0] acc_a, acc_s, acc_p, acc_n;
  logic [AW-1:0] bm, cm, radius_ext;
  logic [PW-1:0] bb, ac, prod_ext;

  logic [DIST_BITS-1:0]       best_dist;
  logic [2:0][COORD_BITS-1:0] best;
  logic                       any_hit;
  logic                       s_lt_best;

  logic                       out_valid;
  logic                       out_hit;
  logic [2:0][COORD_BITS-1:0] out_pos;

  function automatic logic [W-1:0] sel3(input logic [2:0][W-1:0] arr, input logic [1:0] ax);
    case (ax)
      2'd0:    return arr[0];
      2'd1:    return arr[1];
      default: return arr[2];
    endcase
  endfunction

  function automatic logic sel3b(input logic [2:0] arr, input logic [1:0] ax);
    case (ax)
      2'd0:    return arr[0];
      2'd1:    return arr[1];
      default: return arr[2];
    endcase
  endfunction

  assign vin[0] = vert_x;
  assign vin[1] = vert_y;
  assign vin[2] = vert_z;

  // Sign and magnitude of the ray direction and of origin minus vertex.
  always_comb begin
    logic [W-1:0] vext;
    logic [W-1:0] dext;
    for (int k = 0; k < 3; k++) begin
      vext         = {dir[k][COORD_BITS-1], dir[k]};
      vneg[k]      = vext[W-1];
      vmag[k]      = vneg[k] ? (~vext + W'(1)) : vext;
      dext         = {origin[k][COORD_BITS-1], origin[k]} - {vin[k][COORD_BITS-1], vin[k]};
      dneg_next[k] = dext[W-1];
      dmag_next[k] = dneg_next[k] ? (~dext + W'(1)) : dext;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = sel3b(vneg, cmd.axis) ^ sel3b(dneg, cmd.axis);
    case (cmd.op)
      OP_SS: begin
        mul_a = sel3(dmag, cmd.axis);
        mul_b = sel3(dmag, cmd.axis);
      end
      OP_PN: begin
        mul_a = sel3(vmag, cmd.axis);
        mul_b = sel3(dmag, cmd.axis);
      end
      OP_AA: begin
        mul_a = sel3(vmag, cmd.axis);
        mul_b = sel3(vmag, cmd.axis);
      end
      OP_BB_LL: begin
        mul_a = bm[W-1:0];
        mul_b = bm[W-1:0];
      end
      OP_BB_LH: begin
        mul_a = bm[W-1:0];
        mul_b = bm[AW-1:W];
      end
      OP_BB_HH: begin
        mul_a = bm[AW-1:W];
        mul_b = bm[AW-1:W];
      end
      OP_AC_LL: begin
        mul_a = acc_a[W-1:0];
        mul_b = cm[W-1:0];
      end
      OP_AC_LH: begin
        mul_a = acc_a[W-1:0];
        mul_b = cm[AW-1:W];
      end
      OP_AC_HL: begin
        mul_a = acc_a[AW-1:W];
        mul_b = cm[W-1:0];
      end
      OP_AC_HH: begin
        mul_a = acc_a[AW-1:W];
        mul_b = cm[AW-1:W];
      end
      default: begin
      end
    endcase
  end

  assign prod_ext   = PW'(prod);
  assign radius_ext = AW'(radius_sq);
  assign s_lt_best  = CW'(acc_s) < CW'(best_dist);

  // Status back to the controller.
  assign status.last     = last;
  assign status.s_le_r   = acc_s <= radius_ext;
  assign status.p_le_n   = acc_p <= acc_n;
  assign status.bb_ge_ac = bb >= ac;
  assign status.out_free = !out_valid || pick.ready;

  // Result channel.
  assign pick.valid  = out_valid;
  assign pick.hit    = out_hit;
  assign pick.pick_x = out_pos[0];
  assign pick.pick_y = out_pos[1];
  assign pick.pick_z = out_pos[2];

  // Control state: product tag, running best vertex and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op   <= OP_NONE;
      any_hit   <= 1'b0;
      best_dist <= LIMIT_DIST_SQ;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      prod_op <= cmd.op;
      if (cmd.update) begin
        any_hit <= 1'b1;
        if (s_lt_best) begin
          best_dist <= DIST_BITS'(acc_s);
          best      <= vert;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        any_hit   <= 1'b0;
        best_dist <= LIMIT_DIST_SQ;
        best      <= '0;
      end else if (pick.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: vertex, magnitudes, product and accumulators.
  always_ff @(posedge clk) begin
    prod     <= AW'(mul_a) * AW'(mul_b);
    prod_neg <= mul_neg;

    // Accumulate the product issued in the previous cycle.
    case (prod_op)
      OP_SS:    acc_s <= acc_s + prod;
      OP_PN: begin
        if (prod_neg) begin
          acc_n <= acc_n + prod;
        end else begin
          acc_p <= acc_p + prod;
        end
      end
      OP_AA:    acc_a <= acc_a + prod;
      OP_BB_LL: bb <= bb + prod_ext;
      OP_BB_LH: bb <= bb + (prod_ext << (W + 1));
      OP_BB_HH: bb <= bb + (prod_ext << AW);
      OP_AC_LL: ac <= ac + prod_ext;
      OP_AC_LH: ac <= ac + (prod_ext << W);
      OP_AC_HL: ac <= ac + (prod_ext << W);
      OP_AC_HH: ac <= ac + (prod_ext << AW);
      default: begin
      end
    endcase

    // New vertex: capture it and clear the sums.
    if (cmd.load) begin
      vert  <= vin;
      last  <= last_vertex;
      dmag  <= dmag_next;
      dneg  <= dneg_next;
      acc_a <= '0;
      acc_s <= '0;
      acc_p <= '0;
      acc_n <= '0;
    end

    // Form -B and C for the discriminant and clear the wide products.
    if (cmd.prep) begin
      bm <= acc_n - acc_p;
      cm <= acc_s - radius_ext;
      bb <= '0;
      ac <= '0;
    end

    // Result payload.
    if (cmd.emit) begin
      out_hit <= any_hit;
      out_pos <= best;
    end
  end

endmodule

@@ rtl/rsvp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsvp_ctrl: pick sequencer
// Steps one vertex through the sums of products, the hit test, the best
// vertex update and, on the last vertex, the result transfer.
// ----------------------------------------------------------------------------
module rsvp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vert_valid,
  output logic                 vert_ready,
  output rsvp_pkg::dp_cmd_t    cmd,
  input  rsvp_pkg::dp_status_t status
);
  import rsvp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MDRAIN,
    S_EVAL,
    S_WIDE,
    S_WDRAIN,
    S_CMP,
    S_UPDATE,
    S_FINISH
  } state_t;

  localparam logic [3:0] MUL_LAST  = 4'd8;
  localparam logic [3:0] WIDE_LAST = 4'd6;

  state_t     state;
  logic [3:0] step;

  assign vert_ready = (state == S_IDLE);

  // Commands for the current state and step.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load = vert_valid;
      S_MUL: begin
        case (step)
          4'd0: begin cmd.op = OP_SS; cmd.axis = 2'd0; end
          4'd1: begin cmd.op = OP_SS; cmd.axis = 2'd1; end
          4'd2: begin cmd.op = OP_SS; cmd.axis = 2'd2; end
          4'd3: begin cmd.op = OP_PN; cmd.axis = 2'd0; end
          4'd4: begin cmd.op = OP_PN; cmd.axis = 2'd1; end
          4'd5: begin cmd.op = OP_PN; cmd.axis = 2'd2; end
          4'd6: begin cmd.op = OP_AA; cmd.axis = 2'd0; end
          4'd7: begin cmd.op = OP_AA; cmd.axis = 2'd1; end
          4'd8: begin cmd.op = OP_AA; cmd.axis = 2'd2; end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_EVAL:   cmd.prep = 1'b1;
      S_WIDE: begin
        case (step)
          4'd0:    cmd.op = OP_BB_LL;
          4'd1:    cmd.op = OP_BB_LH;
          4'd2:    cmd.op = OP_BB_HH;
          4'd3:    cmd.op = OP_AC_LL;
          4'd4:    cmd.op = OP_AC_LH;
          4'd5:    cmd.op = OP_AC_HL;
          4'd6:    cmd.op = OP_AC_HH;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_UPDATE: cmd.update = 1'b1;
      S_FINISH: cmd.emit = status.last && status.out_free;
      default: begin
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (vert_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == MUL_LAST) begin
            step  <= '0;
            state <= S_MDRAIN;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_MDRAIN: state <= S_EVAL;
        S_EVAL: begin
          step <= '0;
          if (status.s_le_r) begin
            state <= S_UPDATE;
          end else if (status.p_le_n) begin
            state <= S_WIDE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_WIDE: begin
          if (step == WIDE_LAST) begin
            step  <= '0;
            state <= S_WDRAIN;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_WDRAIN: state <= S_CMP;
        S_CMP:    state <= status.bb_ge_ac ? S_UPDATE : S_FINISH;
        S_UPDATE: state <= S_FINISH;
        S_FINISH: begin
          if (!status.last || status.out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ray_sphere_vertex_pick_unit.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_vertex_pick_unit: nearest vertex ray pick
// Tests each vertex sphere against the configured ray with exact integer
// arithmetic and reports the nearest hit vertex at the end of each pick.
//
//   Channel  Dir  Handshake     Payload
//   cfg      in   valid/ready   index, data (register write)
//   vert     in   valid/ready   vert_x, vert_y, vert_z, last_vertex
//   pick     out  valid/ready   hit, pick_x, pick_y, pick_z
//
// A vertex ends after the sums when the sign of B rules out a hit or the
// radius test settles it, and otherwise after B*B and A*C are formed; every
// hit adds a best vertex update, and one shared multiplier issues every
// product in turn.
// rst is synchronous: it restores the register reset values and clears the
// pick. The result sits in an output register; the last vertex waits in its
// final cycle only while an earlier result is still not transferred.
// ----------------------------------------------------------------------------
module ray_sphere_vertex_pick_unit #(
  parameter int COORD_BITS = rsvp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rsvp_cfg_if.sink    cfg,
  rsvp_vert_if.sink   vert,
  rsvp_pick_if.source pick
);
  import rsvp_pkg::*;

  logic [2:0][COORD_BITS-1:0] origin;
  logic [2:0][COORD_BITS-1:0] dir;
  logic [RADIUS_BITS-1:0]     radius_sq;
  dp_cmd_t                    cmd;
  dp_status_t                 status;

  // Configuration registers.
  rsvp_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .origin    (origin),
    .dir       (dir),
    .radius_sq (radius_sq)
  );

  // Sequencer.
  rsvp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .vert_valid (vert.valid),
    .vert_ready (vert.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // Arithmetic and result register.
  rsvp_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .origin      (origin),
    .dir         (dir),
    .radius_sq   (radius_sq),
    .vert_x      (vert.vert_x),
    .vert_y      (vert.vert_y),
    .vert_z      (vert.vert_z),
    .last_vertex (vert.last_vertex),
    .pick        (pick)
  );

endmodule
